// ===== hdl/ddef_pkg.sv =====
package ddef_pkg;

  localparam int MAX_RADIUS_DEF = 15;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 8;
  localparam int RAD_W     = 4;
  localparam int DIM_W     = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
  localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
  localparam logic [DIM_W-1:0] DIM_MIN   = 9'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS,
    REG_GROW,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE,
    OP_EVAL
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FIN
  } state_e;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/disc_dilate_erode_filter.sv =====
// Disc dilation / erosion over an 8-bit frame store.
// Input channel (in_valid_i / in_stall_o): a write word stores pixel_value_i at
// (col_i, line_i) and gives no result; an evaluate word returns one result word
// with the maximum (grow mode) or minimum (shrink mode) over a disc of the
// configured radius, offsets outside the frame counting as 0.
// Output channel (out_valid_o / out_stall_i): filtered_value_o and coord_error_o.
// An evaluate walks every offset of the (2r+1) x (2r+1) square through the single
// frame store port, one read per cycle, into one shared max/min compare unit;
// after the walk and drain states, the finish state loads the output register
// once it is free and the block returns to idle to take the next word. An
// evaluate outside the frame skips the walk and returns 0 with coord_error_o
// set. in_stall_o is high while an evaluate is in progress.
// The output register holds a result while out_stall_i is high; a write may be
// accepted meanwhile, but a further evaluate waits before loading its result.
// Reset restores radius 0, grow mode, a 256 x 256 frame and an idle block; the
// frame store is not cleared and must be written before it is read. Users must
// write configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) while idle; unchecked.
module disc_dilate_erode_filter #(
  parameter int MAX_RADIUS = ddef_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = ddef_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ddef_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ddef_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ddef_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic [ddef_pkg::COORD_W-1:0]     col_i,
  input  logic [ddef_pkg::COORD_W-1:0]     line_i,
  input  logic [ddef_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ddef_pkg::PIX_W-1:0]       filtered_value_o,
  output logic                             coord_error_o
);

  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int OW    = RW + 1;
  localparam int KW    = ddef_pkg::imax(ddef_pkg::RAD_W, RW);
  localparam int DW    = ddef_pkg::imax(
                           ddef_pkg::imax(ddef_pkg::DIM_W, $clog2(MAX_WIDTH + 1)),
                           ddef_pkg::imax($clog2(MAX_HEIGHT + 1), RW + 1));
  localparam int CW    = DW + 2;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SQW   = 2 * RW + 1;
  localparam int PW    = ddef_pkg::PIX_W;

  logic [ddef_pkg::RAD_W-1:0] rad_q;
  logic                       grow_q;
  logic [ddef_pkg::DIM_W-1:0] fw_q;
  logic [ddef_pkg::DIM_W-1:0] fh_q;

  logic [RW-1:0] rc;
  logic [DW-1:0] wc;
  logic [DW-1:0] hc;

  ddef_pkg::state_e state_q, state_d;

  logic [ddef_pkg::COORD_W-1:0] x_q, y_q;
  logic [RW-1:0]                r_q;
  logic signed [OW-1:0]         dx_q, dy_q;
  logic [PW-1:0]                acc_q, acc_d;
  logic                         err_q;
  logic                         pend_q, use_q, zero_q;

  logic [PW-1:0] out_value_q;
  logic          out_err_q;
  logic          out_valid_q;

  logic in_acc, is_eval, bad_coord, in_store;
  logic walk_en, load_out, out_free, ram_we;
  logic last_dx, last_pt;
  logic signed [OW-1:0] r_s;
  logic signed [CW-1:0] xx, yy;
  logic [RW-1:0]  adx, ady;
  logic [SQW-1:0] dsq, rsq;
  logic in_disc, in_frame;
  logic [AW-1:0] wr_addr, walk_addr, ram_addr;
  logic [PW-1:0] ram_rdata, smp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      grow_q <= 1'b1;
      fw_q   <= ddef_pkg::DIM_RESET;
      fh_q   <= ddef_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (ddef_pkg::cfg_reg_e'(cfg_idx_i))
        ddef_pkg::REG_RADIUS: rad_q  <= cfg_wdata_i[ddef_pkg::RAD_W-1:0];
        ddef_pkg::REG_GROW:   grow_q <= cfg_wdata_i[0];
        ddef_pkg::REG_WIDTH:  fw_q   <= cfg_wdata_i[ddef_pkg::DIM_W-1:0];
        ddef_pkg::REG_HEIGHT: fh_q   <= cfg_wdata_i[ddef_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rc = (KW'(rad_q) > KW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(rad_q);
    if (fw_q < ddef_pkg::DIM_MIN) begin
      wc = DW'(ddef_pkg::DIM_MIN);
    end else if (DW'(fw_q) > DW'(MAX_WIDTH)) begin
      wc = DW'(MAX_WIDTH);
    end else begin
      wc = DW'(fw_q);
    end
    if (fh_q < ddef_pkg::DIM_MIN) begin
      hc = DW'(ddef_pkg::DIM_MIN);
    end else if (DW'(fh_q) > DW'(MAX_HEIGHT)) begin
      hc = DW'(MAX_HEIGHT);
    end else begin
      hc = DW'(fh_q);
    end
  end

  assign in_acc    = in_valid_i && !in_stall_o;
  assign is_eval   = ddef_pkg::op_e'(opcode_i) == ddef_pkg::OP_EVAL;
  assign bad_coord = (DW'(col_i) >= wc) || (DW'(line_i) >= hc);
  assign in_store  = (DW'(col_i) < DW'(MAX_WIDTH)) && (DW'(line_i) < DW'(MAX_HEIGHT));
  assign out_free  = !out_valid_q || !out_stall_i;

  assign r_s     = $signed({1'b0, r_q});
  assign last_dx = dx_q == r_s;
  assign last_pt = last_dx && (dy_q == r_s);

  always_comb begin
    xx  = $signed({{(CW - ddef_pkg::COORD_W){1'b0}}, x_q})
        + $signed({{(CW - OW){dx_q[OW-1]}}, dx_q});
    yy  = $signed({{(CW - ddef_pkg::COORD_W){1'b0}}, y_q})
        + $signed({{(CW - OW){dy_q[OW-1]}}, dy_q});
    adx = dx_q[OW-1] ? RW'(-dx_q) : RW'(dx_q);
    ady = dy_q[OW-1] ? RW'(-dy_q) : RW'(dy_q);
    dsq = SQW'(adx) * SQW'(adx) + SQW'(ady) * SQW'(ady);
    rsq = SQW'(r_q) * SQW'(r_q);
    in_disc  = dsq <= rsq;
    in_frame = !xx[CW-1] && (xx < $signed({2'b00, wc}))
            && !yy[CW-1] && (yy < $signed({2'b00, hc}));
  end

  assign wr_addr   = AW'(line_i) * AW'(MAX_WIDTH) + AW'(col_i);
  assign walk_addr = AW'(yy[YW-1:0]) * AW'(MAX_WIDTH) + AW'(xx[XW-1:0]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddef_pkg::ST_IDLE: begin
        if (in_acc && is_eval) begin
          state_d = bad_coord ? ddef_pkg::ST_FIN : ddef_pkg::ST_WALK;
        end
      end
      ddef_pkg::ST_WALK: begin
        if (last_pt) begin
          state_d = ddef_pkg::ST_DRAIN;
        end
      end
      ddef_pkg::ST_DRAIN: state_d = ddef_pkg::ST_FIN;
      ddef_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = ddef_pkg::ST_IDLE;
        end
      end
      default: state_d = ddef_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    walk_en    = 1'b0;
    load_out   = 1'b0;
    ram_addr   = walk_addr;
    unique case (state_q)
      ddef_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_addr   = wr_addr;
      end
      ddef_pkg::ST_WALK:  walk_en = 1'b1;
      ddef_pkg::ST_DRAIN: ;
      ddef_pkg::ST_FIN:   load_out = out_free;
      default: ;
    endcase
  end

  assign ram_we = in_acc && !is_eval && in_store;

  ddef_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pixel_value_i),
    .rdata_o (ram_rdata)
  );

  assign smp = zero_q ? ddef_pkg::PIX_ZERO : ram_rdata;

  always_comb begin
    acc_d = acc_q;
    if (in_acc && is_eval) begin
      acc_d = (grow_q || bad_coord) ? ddef_pkg::PIX_ZERO : ddef_pkg::PIX_MAX;
    end else if (pend_q && use_q) begin
      if (grow_q) begin
        acc_d = (smp > acc_q) ? smp : acc_q;
      end else begin
        acc_d = (smp < acc_q) ? smp : acc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddef_pkg::ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= walk_en;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    use_q  <= in_disc;
    zero_q <= !in_frame;
    if (in_acc && is_eval) begin
      x_q   <= col_i;
      y_q   <= line_i;
      r_q   <= rc;
      dx_q  <= -$signed({1'b0, rc});
      dy_q  <= -$signed({1'b0, rc});
      err_q <= bad_coord;
    end else if (walk_en) begin
      if (last_dx) begin
        dx_q <= -r_s;
        dy_q <= dy_q + OW'(1);
      end else begin
        dx_q <= dx_q + OW'(1);
      end
    end
    if (load_out) begin
      out_value_q <= acc_q;
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign coord_error_o    = out_err_q;

  a_store_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ddef_pkg::ST_IDLE)
    else $error("frame store written during a walk");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && coord_error_o) |-> filtered_value_o == ddef_pkg::PIX_ZERO)
    else $error("coordinate error with non-zero value");

  a_pend_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q) == ddef_pkg::ST_WALK)
    else $error("sample pending without a walk cycle");

  a_drain_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ddef_pkg::ST_DRAIN |=> state_q == ddef_pkg::ST_FIN)
    else $error("drain not followed by finish");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a held word");

endmodule

// ===== hdl/ddef_ram.sv =====
module ddef_ram #(
  parameter int WIDTH = ddef_pkg::PIX_W,
  parameter int DEPTH = ddef_pkg::MAX_WIDTH_DEF * ddef_pkg::MAX_HEIGHT_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_disc_dilate_erode_filter.sv =====
module tb_disc_dilate_erode_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import ddef_pkg::*;

  localparam int STORE_W       = MAX_WIDTH_DEF;
  localparam int STORE_H       = MAX_HEIGHT_DEF;
  localparam int RAND_WORDS    = 620;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 5000;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             err;
  } filt_result_t;

  class filter_scoreboard;
    bit [PIX_W-1:0] frame_mem [STORE_W*STORE_H];
    bit [RAD_W-1:0] radius;
    bit             grow;
    bit [DIM_W-1:0] width;
    bit [DIM_W-1:0] height;
    filt_result_t   expected_q [$];
    int             errors;

    function new();
      radius = '0;
      grow   = 1'b1;
      width  = DIM_RESET;
      height = DIM_RESET;
      errors = 0;
    endfunction

    static function int clip_dim(bit [DIM_W-1:0] v, int hi);
      if (v < DIM_MIN) return int'(DIM_MIN);
      if (v > hi) return hi;
      return int'(v);
    endfunction

    function void set_reg(cfg_reg_e idx, bit [CFG_W-1:0] data);
      case (idx)
        REG_RADIUS: radius = data[RAD_W-1:0];
        REG_GROW:   grow   = data[0];
        REG_WIDTH:  width  = data[DIM_W-1:0];
        REG_HEIGHT: height = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Grayscale max or min over the disc; offsets off the frame read as zero.
    function void note_input(op_e op, bit [COORD_W-1:0] col, bit [COORD_W-1:0] row,
                             bit [PIX_W-1:0] pv);
      int w, h, r, xx, yy;
      bit [PIX_W-1:0] v, s;
      filt_result_t want;
      if (op == OP_WRITE) begin
        frame_mem[int'(row)*STORE_W + int'(col)] = pv;
        return;
      end
      w = clip_dim(width, STORE_W);
      h = clip_dim(height, STORE_H);
      r = int'(radius);
      if (r > MAX_RADIUS_DEF) r = MAX_RADIUS_DEF;
      if (int'(col) >= w || int'(row) >= h) begin
        want.value = PIX_ZERO;
        want.err   = 1'b1;
        expected_q = {expected_q, want};
        return;
      end
      v = frame_mem[int'(row)*STORE_W + int'(col)];
      for (int dy = -r; dy <= r; dy++) begin
        for (int dx = -r; dx <= r; dx++) begin
          if (dx*dx + dy*dy > r*r) continue;
          xx = int'(col) + dx;
          yy = int'(row) + dy;
          if (xx < 0 || xx >= w || yy < 0 || yy >= h) s = PIX_ZERO;
          else s = frame_mem[yy*STORE_W + xx];
          if (grow ? (s > v) : (s < v)) v = s;
        end
      end
      want.value = v;
      want.err   = 1'b0;
      expected_q = {expected_q, want};
    endfunction

    function void check_result(logic [PIX_W-1:0] value, logic err);
      filt_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, filtered_value %0d coord_error %0b",
                 $time, value, err);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value) begin
        $display("%0t: filtered_value expected %0d actual %0d", $time, want.value, value);
        errors++;
      end
      if (err !== want.err) begin
        $display("%0t: coord_error expected %0b actual %0b", $time, want.err, err);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic [COORD_W-1:0]   col_i;
  logic [COORD_W-1:0]   line_i;
  logic [PIX_W-1:0]     pixel_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [PIX_W-1:0]     filtered_value_o;
  logic                 coord_error_o;

  filter_scoreboard sb;
  bit  issued [STORE_W*STORE_H];
  int  cur_radius;
  int  cur_w;
  int  cur_h;
  int  words_sent;
  int  rand_end;
  int  quiet_mark;
  int  idle_cycles;
  bit  quiet;
  bit  send_gaps;

  disc_dilate_erode_filter u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      repeat ($urandom_range(0, 40)) @(posedge clk_i);
      if (!quiet) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(filtered_value_o, coord_error_o);
      if (in_valid_i && !in_stall_o)
        sb.note_input(op_e'(opcode_i), col_i, line_i, pixel_value_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_disc_dilate_erode_filter: errors");
        $finish;
      end
    end
  end

  task automatic send_word(input op_e op, input int x, input int y, input int pv);
    if (send_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    col_i         <= COORD_W'(x);
    line_i        <= COORD_W'(y);
    pixel_value_i <= PIX_W'(pv);
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic put_pixel(input int x, input int y, input int v);
    send_word(OP_WRITE, x, y, v);
    issued[y*STORE_W + x] = 1'b1;
  endtask

  // Store every pixel of the disc before it is read.
  task automatic evaluate(input int x, input int y);
    int xx, yy;
    if (x < cur_w && y < cur_h) begin
      for (int dy = -cur_radius; dy <= cur_radius; dy++) begin
        for (int dx = -cur_radius; dx <= cur_radius; dx++) begin
          if (dx*dx + dy*dy > cur_radius*cur_radius) continue;
          xx = x + dx;
          yy = y + dy;
          if (xx >= 0 && xx < cur_w && yy >= 0 && yy < cur_h && !issued[yy*STORE_W + xx])
            put_pixel(xx, yy, $urandom_range(0, 255));
        end
      end
    end
    send_word(OP_EVAL, x, y, $urandom_range(0, 255));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input bit [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(input int r, input bit g, input bit [DIM_W-1:0] w,
                              input bit [DIM_W-1:0] h);
    write_reg(REG_RADIUS, {(CFG_W-RAD_W)'($urandom), RAD_W'(r)});
    write_reg(REG_GROW, {(CFG_W-1)'($urandom), g});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_we_i   <= 1'b0;
    cur_radius = r;
    cur_w      = filter_scoreboard::clip_dim(w, STORE_W);
    cur_h      = filter_scoreboard::clip_dim(h, STORE_H);
  endtask

  function automatic bit [DIM_W-1:0] random_dim();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return DIM_W'($urandom_range(1, 24));
    if (pick < 60) return DIM_RESET;
    if (pick < 80) return DIM_W'($urandom_range(1, 256));
    return $urandom_range(0, 1) ? '0 : DIM_W'($urandom_range(257, 511));
  endfunction

  // Keep centres near the origin so the stored area grows slowly.
  function automatic int centre_coord(input int dim);
    if (dim <= 24) return $urandom_range(0, dim - 1);
    if (cur_radius <= 3 && $urandom_range(0, 4) == 0) return $urandom_range(dim - 4, dim - 1);
    return $urandom_range(0, cur_radius > 8 ? 3 : 15);
  endfunction

  task automatic random_phase();
    int pick, r, x, y;
    bit [DIM_W-1:0] w, h;
    pick = $urandom_range(0, 99);
    if (pick < 60) r = $urandom_range(0, 3);
    else if (pick < 85) r = $urandom_range(4, 8);
    else r = $urandom_range(9, MAX_RADIUS_DEF);
    w = random_dim();
    h = random_dim();
    wait_drained();
    program_regs(r, 1'($urandom), w, h);
    send_gaps = $urandom_range(0, 2) != 0;
    repeat ($urandom_range(8, 40)) begin
      if (words_sent >= rand_end) break;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        x = centre_coord(cur_w);
        y = centre_coord(cur_h);
        evaluate(x, y);
      end else if (pick < 75 && (cur_w < STORE_W || cur_h < STORE_H)) begin
        if (cur_w < STORE_W && (cur_h == STORE_H || $urandom_range(0, 1) == 1)) begin
          x = $urandom_range(cur_w, 255);
          y = $urandom_range(0, 255);
        end else begin
          x = $urandom_range(0, 255);
          y = $urandom_range(cur_h, 255);
        end
        send_word(OP_EVAL, x, y, $urandom_range(0, 255));
      end else begin
        put_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end
      if (words_sent >= quiet_mark) quiet = 1'b1;
    end
  endtask

  initial begin
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_RADIUS;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    opcode_i      = OP_WRITE;
    col_i         = '0;
    line_i        = '0;
    pixel_value_i = '0;
    quiet         = 1'b0;
    send_gaps     = 1'b1;
    words_sent    = 0;
    rand_end      = 0;
    idle_cycles   = 0;
    quiet_mark    = 1 << 30;
    cur_radius    = 0;
    cur_w         = STORE_W;
    cur_h         = STORE_H;
    sb = new();
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: pixels pass straight through
    put_pixel(255, 255, PIX_MAX);
    put_pixel(0, 0, PIX_ZERO);
    put_pixel(0, 255, 8'hAA);
    put_pixel(255, 0, 8'h55);
    evaluate(255, 255);
    evaluate(0, 0);
    evaluate(0, 255);
    wait_drained();
    program_regs(1, 1'b1, DIM_RESET, DIM_RESET);
    evaluate(255, 255);
    evaluate(0, 0);
    wait_drained();
    // erosion at an edge sees the zero border
    program_regs(1, 1'b0, DIM_RESET, DIM_RESET);
    evaluate(255, 255);
    evaluate(128, 128);
    wait_drained();
    // out-of-range frame sizes saturate
    program_regs(0, 1'b1, '0, 9'd511);
    evaluate(0, 0);
    evaluate(1, 0);
    evaluate(255, 255);
    wait_drained();
    program_regs(MAX_RADIUS_DEF, 1'b0, DIM_MIN, DIM_MIN);
    evaluate(0, 0);
    evaluate(0, 1);
    wait_drained();
    program_regs(MAX_RADIUS_DEF, 1'b1, DIM_MIN, DIM_MIN);
    evaluate(0, 0);

    rand_end   = words_sent + RAND_WORDS;
    quiet_mark = words_sent + RAND_WORDS * 17 / 20;
    while (words_sent < rand_end) random_phase();

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_disc_dilate_erode_filter: clean");
    end else begin
      $display("tb_disc_dilate_erode_filter: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ddef_pkg.sv
hdl/ddef_ram.sv
hdl/disc_dilate_erode_filter.sv
tb/tb_disc_dilate_erode_filter.sv
